### rtl/core/ffh_pkg.sv
// Shared types and constants for the first-fit heap manager.
`timescale 1ns / 1ps
package ffh_pkg;

   localparam int MAX_BLOCKS_DEF = 16;
   localparam int MAX_REFS_DEF   = 15;
   localparam int MAX_RESULTS    = 16;
   localparam int KW             = $clog2(MAX_RESULTS + 1);
   localparam logic [15:0] HEAP_RESET = 16'd1024;
   localparam logic [15:0] UNIT_BYTES = 16'd8;

   // Item commands
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_SWEEP  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_ABSENT  = 3'd2,
      ST_DUP     = 3'd3,
      ST_FULL    = 3'd4
   } rs_type;

   // Datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NOP, OP_INIT, OP_LOAD, OP_IDX0, OP_ASCAN, OP_FSCAN, OP_CARVE,
      OP_AINS, OP_TAKE, OP_TAKES, OP_SNEXT, OP_AREM, OP_FINS, OP_MNEXT,
      OP_MPREV, OP_FREM, OP_HOLD, OP_EMIT, OP_SWEND
   } op_type;

   typedef struct packed {
      op_type op;
      rs_type code;
   } cmd_type;

   typedef struct packed {
      logic       a_hit;
      logic       a_end;
      logic       a_full;
      logic       f_hit;
      logic       f_end;
      logic       f_full;
      logic       ains_done;
      logic       arem_done;
      logic       fins_done;
      logic       frem_done;
      logic       m_next;
      logic       m_prev;
      logic       s_hit;
      logic       s_end;
      logic       hold_v;
      logic       out_free;
      logic [1:0] cmd;
   } stat_type;

endpackage

### rtl/core/ffh_if.sv
// Handshake channel interfaces: request, response and register write.
`timescale 1ns / 1ps
interface ffh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] block_id;
   logic [3:0] link_count;
   logic       reachable_mark;
   modport source (output valid, command, block_id, link_count, reachable_mark,
                   input ready);
   modport sink (input valid, command, block_id, link_count, reachable_mark,
                 output ready);
endinterface

interface ffh_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  result_id;
   logic [15:0] start_address;
   logic [15:0] block_size;
   logic [15:0] free_total;
   logic        last;
   modport source (output valid, status, result_id, start_address, block_size,
                   free_total, last, input ready);
   modport sink (input valid, status, result_id, start_address, block_size,
                 free_total, last, output ready);
endinterface

interface ffh_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] heap_size;
   modport source (output valid, heap_size, input ready);
   modport sink (input valid, heap_size, output ready);
endinterface

### rtl/core/ffh_ctrl.sv
// Sequencer for allocate, free and sweep: one table step per cycle while no result waits on a busy output.
`timescale 1ns / 1ps
module ffh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  ffh_pkg::stat_type  sts,
   output ffh_pkg::cmd_type   ctl
);
   import ffh_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_DISP  = 15'b000000000000010,
      S_ADUP  = 15'b000000000000100,
      S_AFIT  = 15'b000000000001000,
      S_AINS  = 15'b000000000010000,
      S_EMIT  = 15'b000000000100000,
      S_FFIND = 15'b000000001000000,
      S_AREM  = 15'b000000010000000,
      S_FINS  = 15'b000000100000000,
      S_MNEXT = 15'b000001000000000,
      S_MPREV = 15'b000010000000000,
      S_FREM  = 15'b000100000000000,
      S_HOLD  = 15'b001000000000000,
      S_SSCAN = 15'b010000000000000,
      S_SWEND = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   rs_type    code_ff, code_in;
   logic      ret_ff, ret_in;
   state_type done_state;
   rs_type    done_code;

   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;

   // where a finished release goes: sweep keeps walking, free reports
   always_comb begin
      done_state = (sts.cmd == CMD_SWEEP) ? S_HOLD : S_EMIT;
      done_code  = (sts.cmd == CMD_SWEEP) ? code_ff : ST_OK;
   end

   // next state and datapath operation
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      ret_in   = ret_ff;
      ctl.op   = OP_NOP;
      ctl.code = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               ctl.op = OP_INIT;
            end else if (req_valid) begin
               ctl.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.cmd)
               CMD_ALLOC: state_in = S_ADUP;
               CMD_FREE:  state_in = S_FFIND;
               CMD_SWEEP: state_in = S_SSCAN;
               default:   state_in = S_IDLE;
            endcase
         end
         S_ADUP: begin
            if (sts.a_hit) begin
               code_in  = ST_DUP;
               state_in = S_EMIT;
            end else if (sts.a_end) begin
               if (sts.a_full) begin
                  code_in  = ST_FULL;
                  state_in = S_EMIT;
               end else begin
                  ctl.op   = OP_IDX0;
                  state_in = S_AFIT;
               end
            end else begin
               ctl.op = OP_ASCAN;
            end
         end
         S_AFIT: begin
            if (sts.f_hit) begin
               ctl.op   = OP_CARVE;
               state_in = S_AINS;
            end else if (sts.f_end) begin
               code_in  = ST_NOSPACE;
               state_in = S_EMIT;
            end else begin
               ctl.op = OP_FSCAN;
            end
         end
         S_AINS: begin
            ctl.op = OP_AINS;
            if (sts.ains_done) begin
               code_in  = ST_OK;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               ctl.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         S_FFIND: begin
            if (sts.a_hit) begin
               ctl.op   = OP_TAKE;
               state_in = S_AREM;
            end else if (sts.a_end) begin
               code_in  = ST_ABSENT;
               state_in = S_EMIT;
            end else begin
               ctl.op = OP_ASCAN;
            end
         end
         S_AREM: begin
            ctl.op = OP_AREM;
            if (sts.arem_done) begin
               // free table full: the block is dropped, not inserted
               if (sts.f_full) begin
                  code_in  = done_code;
                  state_in = done_state;
               end else begin
                  state_in = S_FINS;
               end
            end
         end
         S_FINS: begin
            ctl.op = OP_FINS;
            if (sts.fins_done) state_in = S_MNEXT;
         end
         S_MNEXT: begin
            if (sts.m_next) begin
               ctl.op   = OP_MNEXT;
               ret_in   = 1'b0;
               state_in = S_FREM;
            end else begin
               state_in = S_MPREV;
            end
         end
         S_MPREV: begin
            if (sts.m_prev) begin
               ctl.op   = OP_MPREV;
               ret_in   = 1'b1;
               state_in = S_FREM;
            end else begin
               code_in  = done_code;
               state_in = done_state;
            end
         end
         S_FREM: begin
            ctl.op = OP_FREM;
            if (sts.frem_done) begin
               if (ret_ff) begin
                  code_in  = done_code;
                  state_in = done_state;
               end else begin
                  state_in = S_MPREV;
               end
            end
         end
         S_HOLD: begin
            if (sts.out_free || !sts.hold_v) begin
               ctl.op   = OP_HOLD;
               state_in = S_SSCAN;
            end
         end
         S_SSCAN: begin
            if (sts.s_end) begin
               state_in = S_SWEND;
            end else if (sts.s_hit) begin
               ctl.op   = OP_TAKES;
               state_in = S_AREM;
            end else begin
               ctl.op = OP_SNEXT;
            end
         end
         S_SWEND: begin
            if (sts.out_free) begin
               ctl.op   = OP_SWEND;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

### rtl/core/ffh_dp.sv
// Datapath: free and allocated tables, walk indexes, result registers.
`timescale 1ns / 1ps
module ffh_dp #(
   parameter int MAX_BLOCKS = ffh_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_REFS   = ffh_pkg::MAX_REFS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ffh_pkg::cmd_type   ctl,
   output ffh_pkg::stat_type  sts,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_block_id,
   input  logic [3:0]         req_link_count,
   input  logic               req_reachable_mark,
   input  logic [15:0]        csr_heap_size,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_result_id,
   output logic [15:0]        rsp_start_address,
   output logic [15:0]        rsp_block_size,
   output logic [15:0]        rsp_free_total,
   output logic               rsp_last
);
   import ffh_pkg::*;

   localparam int FD = MAX_BLOCKS + 1;
   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int FW = $clog2(FD);
   localparam int CW = $clog2(MAX_BLOCKS + 2);

   // tables
   logic [15:0] fst_ff [FD];
   logic [15:0] fln_ff [FD];
   logic [7:0]  aid_ff [MAX_BLOCKS];
   logic [15:0] ast_ff [MAX_BLOCKS];
   logic [15:0] aln_ff [MAX_BLOCKS];
   logic        amk_ff [MAX_BLOCKS];

   // counts and walk indexes
   logic [CW-1:0] na_ff, nf_ff, idx_ff, q_ff, s_ff;
   logic [KW-1:0] k_ff;

   // item under work
   logic [1:0]  cmd_ff;
   logic [7:0]  id_ff, rid_ff;
   logic        mark_ff;
   logic [15:0] size_ff, st_ff, len_ff, ft_ff;

   // held sweep result and output register
   logic        hv_ff;
   logic [7:0]  hid_ff;
   logic [15:0] hst_ff, hln_ff, hft_ff;
   logic        rv_ff;
   logic [2:0]  rstat_ff;
   logic [7:0]  rid_out_ff;
   logic [15:0] rst_ff, rln_ff, rft_ff;
   logic        rlast_ff;

   logic [CW-1:0] idx_p1, idx_m1, q_p1, q_m1;
   logic [AW-1:0] ai, ai_p1, ai_m1, si;
   logic [FW-1:0] fi, fi_p1, fi_m1, qi, qi_p1, qi_m1;
   logic [3:0]    refs;
   logic [15:0]   size_calc;
   logic [16:0]   end_q, end_qm1;
   logic          rsp_load;

   assign idx_p1 = idx_ff + 1'b1;
   assign idx_m1 = idx_ff - 1'b1;
   assign q_p1   = q_ff + 1'b1;
   assign q_m1   = q_ff - 1'b1;
   assign ai     = idx_ff[AW-1:0];
   assign ai_p1  = idx_p1[AW-1:0];
   assign ai_m1  = idx_m1[AW-1:0];
   assign si     = s_ff[AW-1:0];
   assign fi     = idx_ff[FW-1:0];
   assign fi_p1  = idx_p1[FW-1:0];
   assign fi_m1  = idx_m1[FW-1:0];
   assign qi     = q_ff[FW-1:0];
   assign qi_p1  = q_p1[FW-1:0];
   assign qi_m1  = q_m1[FW-1:0];

   // block size, references capped
   assign refs = ({4'd0, req_link_count} > 8'(MAX_REFS)) ? 4'(MAX_REFS) : req_link_count;
   assign size_calc = UNIT_BYTES + {9'd0, refs, 3'd0};

   // end addresses for coalescing checks
   assign end_q   = {1'b0, fst_ff[qi]} + {1'b0, fln_ff[qi]};
   assign end_qm1 = {1'b0, fst_ff[qi_m1]} + {1'b0, fln_ff[qi_m1]};

   // status to the controller
   always_comb begin
      sts.a_end     = !(idx_ff < na_ff);
      sts.a_hit     = !sts.a_end && (aid_ff[ai] == id_ff);
      sts.a_full    = (na_ff == CW'(MAX_BLOCKS));
      sts.f_end     = !(idx_ff < nf_ff);
      sts.f_hit     = !sts.f_end && (fln_ff[fi] > size_ff);
      sts.f_full    = (nf_ff == CW'(FD));
      sts.ains_done = !((idx_ff != '0) && (ast_ff[ai_m1] >= st_ff));
      sts.arem_done = !(idx_p1 < na_ff);
      sts.fins_done = !((idx_ff != '0) && (fst_ff[fi_m1] >= st_ff));
      sts.frem_done = !(idx_p1 < nf_ff);
      sts.m_next    = (q_p1 < nf_ff) && (end_q == {1'b0, fst_ff[qi_p1]});
      sts.m_prev    = (q_ff != '0) && (end_qm1 == {1'b0, fst_ff[qi]});
      sts.s_end     = !(s_ff < na_ff) || (k_ff >= KW'(MAX_RESULTS));
      sts.s_hit     = !sts.s_end && !amk_ff[si];
      sts.hold_v    = hv_ff;
      sts.out_free  = !rv_ff || rsp_ready;
      sts.cmd       = cmd_ff;
   end

   assign rsp_load = (ctl.op == OP_EMIT) || (ctl.op == OP_SWEND)
                     || ((ctl.op == OP_HOLD) && hv_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         na_ff <= '0;
         nf_ff <= CW'(1);
         hv_ff <= 1'b0;
         rv_ff <= 1'b0;
         ft_ff <= HEAP_RESET;
      end else begin
         if (rsp_load) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
         case (ctl.op)
            OP_INIT: begin
               na_ff <= '0;
               nf_ff <= CW'(1);
               ft_ff <= csr_heap_size;
            end
            OP_LOAD:  hv_ff <= 1'b0;
            OP_CARVE: ft_ff <= ft_ff - size_ff;
            OP_AINS:  if (sts.ains_done) na_ff <= na_ff + 1'b1;
            // a block released into a full free table is lost
            OP_TAKE:  if (!sts.f_full) ft_ff <= ft_ff + aln_ff[ai];
            OP_TAKES: if (!sts.f_full) ft_ff <= ft_ff + aln_ff[si];
            OP_AREM:  if (sts.arem_done) na_ff <= na_ff - 1'b1;
            OP_FINS:  if (sts.fins_done) nf_ff <= nf_ff + 1'b1;
            OP_FREM:  if (sts.frem_done) nf_ff <= nf_ff - 1'b1;
            OP_HOLD:  hv_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // tables, indexes and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         fst_ff[0] <= '0;
         fln_ff[0] <= HEAP_RESET;
      end else begin
         case (ctl.op)
            OP_INIT: begin
               fst_ff[0] <= '0;
               fln_ff[0] <= csr_heap_size;
            end
            OP_LOAD: begin
               cmd_ff  <= req_command;
               id_ff   <= req_block_id;
               rid_ff  <= req_block_id;
               mark_ff <= req_reachable_mark;
               size_ff <= size_calc;
               idx_ff  <= '0;
               s_ff    <= '0;
               k_ff    <= '0;
            end
            OP_IDX0:  idx_ff <= '0;
            OP_ASCAN: idx_ff <= idx_p1;
            OP_FSCAN: idx_ff <= idx_p1;
            OP_CARVE: begin
               fst_ff[fi] <= fst_ff[fi] + size_ff;
               fln_ff[fi] <= fln_ff[fi] - size_ff;
               st_ff      <= fst_ff[fi];
               len_ff     <= size_ff;
               idx_ff     <= na_ff;
            end
            OP_AINS: begin
               if (!sts.ains_done) begin
                  aid_ff[ai] <= aid_ff[ai_m1];
                  ast_ff[ai] <= ast_ff[ai_m1];
                  aln_ff[ai] <= aln_ff[ai_m1];
                  amk_ff[ai] <= amk_ff[ai_m1];
                  idx_ff     <= idx_m1;
               end else begin
                  aid_ff[ai] <= id_ff;
                  ast_ff[ai] <= st_ff;
                  aln_ff[ai] <= len_ff;
                  amk_ff[ai] <= mark_ff;
               end
            end
            OP_TAKE: begin
               st_ff  <= ast_ff[ai];
               len_ff <= aln_ff[ai];
               rid_ff <= aid_ff[ai];
            end
            OP_TAKES: begin
               st_ff  <= ast_ff[si];
               len_ff <= aln_ff[si];
               rid_ff <= aid_ff[si];
               idx_ff <= s_ff;
            end
            OP_SNEXT: s_ff <= s_ff + 1'b1;
            OP_AREM: begin
               if (!sts.arem_done) begin
                  aid_ff[ai] <= aid_ff[ai_p1];
                  ast_ff[ai] <= ast_ff[ai_p1];
                  aln_ff[ai] <= aln_ff[ai_p1];
                  amk_ff[ai] <= amk_ff[ai_p1];
                  idx_ff     <= idx_p1;
               end else begin
                  idx_ff <= nf_ff;
               end
            end
            OP_FINS: begin
               if (!sts.fins_done) begin
                  fst_ff[fi] <= fst_ff[fi_m1];
                  fln_ff[fi] <= fln_ff[fi_m1];
                  idx_ff     <= idx_m1;
               end else begin
                  fst_ff[fi] <= st_ff;
                  fln_ff[fi] <= len_ff;
                  q_ff       <= idx_ff;
               end
            end
            OP_MNEXT: begin
               fln_ff[qi] <= fln_ff[qi] + fln_ff[qi_p1];
               idx_ff     <= q_p1;
            end
            OP_MPREV: begin
               fln_ff[qi_m1] <= fln_ff[qi_m1] + fln_ff[qi];
               idx_ff        <= q_ff;
            end
            OP_FREM: begin
               if (!sts.frem_done) begin
                  fst_ff[fi] <= fst_ff[fi_p1];
                  fln_ff[fi] <= fln_ff[fi_p1];
                  idx_ff     <= idx_p1;
               end
            end
            OP_HOLD: begin
               hid_ff <= rid_ff;
               hst_ff <= st_ff;
               hln_ff <= len_ff;
               hft_ff <= ft_ff;
               k_ff   <= k_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_EMIT: begin
            rstat_ff   <= ctl.code;
            rid_out_ff <= rid_ff;
            rst_ff     <= (ctl.code == ST_OK) ? st_ff : 16'd0;
            rln_ff     <= (ctl.code == ST_OK) ? len_ff : 16'd0;
            rft_ff     <= ft_ff;
            rlast_ff   <= 1'b1;
         end
         OP_HOLD: begin
            if (hv_ff) begin
               rstat_ff   <= ST_OK;
               rid_out_ff <= hid_ff;
               rst_ff     <= hst_ff;
               rln_ff     <= hln_ff;
               rft_ff     <= hft_ff;
               rlast_ff   <= 1'b0;
            end
         end
         OP_SWEND: begin
            rlast_ff <= 1'b1;
            if (hv_ff) begin
               rstat_ff   <= ST_OK;
               rid_out_ff <= hid_ff;
               rst_ff     <= hst_ff;
               rln_ff     <= hln_ff;
               rft_ff     <= hft_ff;
            end else begin
               rstat_ff   <= ST_ABSENT;
               rid_out_ff <= 8'd0;
               rst_ff     <= 16'd0;
               rln_ff     <= 16'd0;
               rft_ff     <= ft_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = rstat_ff;
   assign rsp_result_id     = rid_out_ff;
   assign rsp_start_address = rst_ff;
   assign rsp_block_size    = rln_ff;
   assign rsp_free_total    = rft_ff;
   assign rsp_last          = rlast_ff;

endmodule

### rtl/core/first_fit_heap_with_mark_sweep.sv
// First-fit heap manager top level: controller, datapath and channel ports.
// Items are taken one at a time. Every table walk advances one entry per
// cycle through the sorted free and allocated tables (depth MAX_BLOCKS+1 and
// MAX_BLOCKS). An allocate runs a duplicate search, a first-fit search and a
// sorted insert; free and sweep run, per released block, a find, a remove, a
// sorted insert and two coalescing removals. A result waits in an output
// register, and the next item is accepted while it waits. A heap_size write
// reinitializes the heap while the block is idle.
`timescale 1ns / 1ps
module first_fit_heap_with_mark_sweep #(
   parameter int MAX_BLOCKS = ffh_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_REFS   = ffh_pkg::MAX_REFS_DEF
) (
   input logic      clock,
   input logic      reset,
   ffh_req_if.sink  req,
   ffh_rsp_if.source rsp,
   ffh_csr_if.sink  csr
);
   import ffh_pkg::*;

   cmd_type  ctl;
   stat_type sts;

   // sequencer
   ffh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .csr_valid (csr.valid),
      .csr_ready (csr.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // tables and result path
   ffh_dp #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .MAX_REFS   (MAX_REFS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req.command),
      .req_block_id       (req.block_id),
      .req_link_count     (req.link_count),
      .req_reachable_mark (req.reachable_mark),
      .csr_heap_size      (csr.heap_size),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_status         (rsp.status),
      .rsp_result_id      (rsp.result_id),
      .rsp_start_address  (rsp.start_address),
      .rsp_block_size     (rsp.block_size),
      .rsp_free_total     (rsp.free_total),
      .rsp_last           (rsp.last)
   );

endmodule

### rtl/core/ffh_check.sv
// Port-level checks for the heap manager, bound to the top level.
`timescale 1ns / 1ps
module ffh_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_start_address,
   input logic [15:0] rsp_block_size,
   input logic        rsp_last
);
   import ffh_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_block_size))
      else $error("result changed while stalled");

   // error results carry no block and end their item
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_start_address == 16'd0)
                  && (rsp_block_size == 16'd0) && rsp_last)
      else $error("error result with block data or without last");

   // good results have a nonzero size in whole units
   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> (rsp_block_size != 16'd0)
                  && (rsp_block_size[2:0] == 3'd0))
      else $error("bad block size");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

endmodule

bind first_fit_heap_with_mark_sweep ffh_check u_ffh_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_start_address (rsp.start_address),
   .rsp_block_size    (rsp.block_size),
   .rsp_last          (rsp.last)
);
